/* rtl/sbae_pkg.sv */
// ----------------------------------------------------------------------------
// sbae_pkg
// Shared widths, limits and the code-to-character map of the six-bit encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sbae_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int MAG_W     = 29;  // saturated magnitude, two spare top bits
  localparam int CODE_W    = 6;
  localparam int ASCII_W   = 7;
  localparam int COL_W     = 7;
  localparam int MAX_CHARS = 6;
  localparam int CNT_W     = 3;
  localparam int GROUP_W   = 5;
  localparam int OUT_DATA_W = 16;

  localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(134217727);
  localparam logic [MAG_W-1:0] LIMIT_1 = MAG_W'(16);
  localparam logic [MAG_W-1:0] LIMIT_2 = MAG_W'(512);
  localparam logic [MAG_W-1:0] LIMIT_3 = MAG_W'(16384);
  localparam logic [MAG_W-1:0] LIMIT_4 = MAG_W'(524288);
  localparam logic [MAG_W-1:0] LIMIT_5 = MAG_W'(16777216);

  localparam logic [CODE_W-1:0]  CONT_BIT     = 6'd32;
  localparam logic [CODE_W-1:0]  SIGN_BIT     = 6'd16;
  localparam logic [ASCII_W-1:0] NEWLINE_CODE = 7'd10;

  typedef logic [CODE_W-1:0] code_t;
  typedef code_t [MAX_CHARS-1:0] code_vec_t;

  // Map a six-bit code onto the alphabet "+-0-9A-Za-z".
  function automatic logic [ASCII_W-1:0] to_ascii(input code_t code);
    logic [ASCII_W-1:0] c;
    c = {1'b0, code};
    if (code == 6'd0) begin
      to_ascii = 7'd43;
    end else if (code == 6'd1) begin
      to_ascii = 7'd45;
    end else if (code < 6'd12) begin
      to_ascii = c + 7'd46;
    end else if (code < 6'd38) begin
      to_ascii = c + 7'd53;
    end else begin
      to_ascii = c + 7'd59;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/six_bit_ascii_sample_encoder_top.sv */
// ----------------------------------------------------------------------------
// six_bit_ascii_sample_encoder_top
// Turns signed samples into six-bit printable characters with line breaks.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                         | tlast        | tuser
//  --------+-----+-------------------------------+--------------+------
//  s_*     | in  | [31:0] sample                 | final_sample | -
//  m_*     | out | [6:0] char_code, [13:7] pad   | last_of_run  | -
//
//  A sample leaves as 1 to 6 characters, plus one newline when the line
//  fills; the output register moves one character per cycle while m_tready
//  does not stall it. The next sample is taken in the cycle its
//  predecessor's last character is issued, so there is no gap between runs.
//  Reset (synchronous) empties both registers and sets the column to zero.
//  A stall on m_tready holds the output register and the sample in flight.
//
`default_nettype none

module six_bit_ascii_sample_encoder_top #(
  parameter int LINE_LENGTH = 80
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [sbae_pkg::SAMPLE_W-1:0]       s_tdata,  // [31:0] sample
  input  wire logic                                s_tlast,  // final_sample
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [sbae_pkg::OUT_DATA_W-1:0]          m_tdata,  // [6:0] char_code,
                                                             // [13:7] pad_blanks
  output logic                                     m_tlast   // last_of_run
);

  localparam logic [sbae_pkg::COL_W-1:0] LINE_LEN = sbae_pkg::COL_W'(LINE_LENGTH);

  // ---------------------------------------------------------------------
  // Front end: sign/magnitude, saturation, character count and codes.
  // ---------------------------------------------------------------------
  logic                                neg;
  logic [sbae_pkg::SAMPLE_W-1:0]       raw_mag;
  logic [sbae_pkg::MAG_W-1:0]          mag;
  logic [sbae_pkg::CNT_W-1:0]          nchars;
  sbae_pkg::code_vec_t                 codes_in;
  logic [sbae_pkg::GROUP_W-1:0]        groups [sbae_pkg::MAX_CHARS];

  always_comb begin
    neg     = s_tdata[sbae_pkg::SAMPLE_W-1];
    raw_mag = neg ? (~s_tdata + 32'd1) : s_tdata;
    // The most negative sample wraps to 2^31 and saturates too.
    if (raw_mag > {{(sbae_pkg::SAMPLE_W-sbae_pkg::MAG_W){1'b0}}, sbae_pkg::MAG_MAX}) begin
      mag = sbae_pkg::MAG_MAX;
    end else begin
      mag = raw_mag[sbae_pkg::MAG_W-1:0];
    end

    if (mag < sbae_pkg::LIMIT_1) begin
      nchars = 3'd1;
    end else if (mag < sbae_pkg::LIMIT_2) begin
      nchars = 3'd2;
    end else if (mag < sbae_pkg::LIMIT_3) begin
      nchars = 3'd3;
    end else if (mag < sbae_pkg::LIMIT_4) begin
      nchars = 3'd4;
    end else if (mag < sbae_pkg::LIMIT_5) begin
      nchars = 3'd5;
    end else begin
      nchars = 3'd6;
    end
  end

  // Five-bit groups, least significant first.
  for (genvar g = 0; g < sbae_pkg::MAX_CHARS - 1; g++) begin : g_groups
    assign groups[g] = mag[g*sbae_pkg::GROUP_W +: sbae_pkg::GROUP_W];
  end
  assign groups[sbae_pkg::MAX_CHARS-1] =
    {1'b0, mag[sbae_pkg::MAG_W-1:(sbae_pkg::MAX_CHARS-1)*sbae_pkg::GROUP_W]};

  // Codes sent first sit in slot 0; slot i carries group nchars-1-i.
  always_comb begin
    for (int i = 0; i < sbae_pkg::MAX_CHARS; i++) begin
      logic [sbae_pkg::CNT_W-1:0] gi;
      gi = nchars - 3'd1 - sbae_pkg::CNT_W'(i);
      codes_in[i] = '0;
      if (sbae_pkg::CNT_W'(i) < nchars) begin
        codes_in[i] = {1'b0, groups[gi]};
        if (sbae_pkg::CNT_W'(i) != nchars - 3'd1) begin
          codes_in[i] = codes_in[i] | sbae_pkg::CONT_BIT;
        end
        if (i == 0 && neg) begin
          codes_in[i] = codes_in[i] | sbae_pkg::SIGN_BIT;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sample register: codes still to send, count left, final flag.
  // ---------------------------------------------------------------------
  logic                          hold_valid;
  sbae_pkg::code_vec_t           codes;
  logic [sbae_pkg::CNT_W-1:0]    left;
  logic                          final_flag;
  logic [sbae_pkg::COL_W-1:0]    column;

  logic                          out_free;
  logic                          emit;
  logic                          newline;
  logic                          release_item;
  logic [sbae_pkg::COL_W-1:0]    col_inc;
  logic [sbae_pkg::COL_W-1:0]    pad;

  always_comb begin
    out_free     = !m_tvalid || m_tready;
    emit         = hold_valid && out_free;
    newline      = column >= LINE_LEN;
    release_item = emit && !newline && (left == 3'd1);
    s_tready     = !hold_valid || release_item;
    col_inc      = column + 7'd1;
    pad          = (col_inc >= LINE_LEN) ? '0 : LINE_LEN - col_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      column     <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // Step the column per character; newline or stream end clears it.
      if (emit) begin
        if (newline) begin
          column <= '0;
        end else if (left == 3'd1 && final_flag) begin
          column <= '0;
        end else begin
          column <= col_inc;
        end
      end

      if (s_tvalid && s_tready) begin
        hold_valid <= 1'b1;
      end else if (release_item) begin
        hold_valid <= 1'b0;
      end

      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      codes      <= codes_in;
      left       <= nchars;
      final_flag <= s_tlast;
    end else if (emit && !newline) begin
      for (int i = 0; i < sbae_pkg::MAX_CHARS - 1; i++) begin
        codes[i] <= codes[i+1];
      end
      codes[sbae_pkg::MAX_CHARS-1] <= '0;
      left <= left - 3'd1;
    end

    if (emit) begin
      if (newline) begin
        m_tdata <= {2'b00, 7'd0, sbae_pkg::NEWLINE_CODE};
        m_tlast <= 1'b0;
      end else begin
        m_tlast <= (left == 3'd1);
        m_tdata <= {2'b00,
                    (left == 3'd1 && final_flag) ? pad : 7'd0,
                    sbae_pkg::to_ascii(codes[0])};
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sbae_checker.sv */
// ----------------------------------------------------------------------------
// sbae_checker
// Port-level checks on the encoder's character stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sbae_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tlast
);

  // Hold a stalled character.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled character changed");

  // A newline never ends a sample's run and carries no padding.
  a_newline: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6:0] == sbae_pkg::NEWLINE_CODE |-> !m_tlast && m_tdata[13:7] == 7'd0)
    else $error("newline marked last or padded");

  // Padding shows only on the last character of a run.
  a_pad_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[13:7] == 7'd0)
    else $error("padding outside run end");

  // Drop output after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind six_bit_ascii_sample_encoder_top sbae_checker u_sbae_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

/* tb/sv/sbae_char_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbae_char_checker
// Predicts the character stream of the six-bit sample encoder and compares
// every character that leaves the block against the prediction.
// ----------------------------------------------------------------------------
module sbae_char_checker #(
  parameter int LINE_LEN = 80
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [sbae_pkg::SAMPLE_W-1:0]    s_tdata,   // [31:0] sample
  input  logic                             s_tlast,   // final_sample
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [sbae_pkg::OUT_DATA_W-1:0]  m_tdata,   // [6:0] char_code, [13:7] pad_blanks
  input  logic                             m_tlast,   // last_of_run
  output int                               chars_due,
  output int                               fail_count
);

  typedef struct packed {
    logic [sbae_pkg::ASCII_W-1:0] ascii;
    logic                         run_end;
    logic [sbae_pkg::COL_W-1:0]   pad;
  } enc_char_t;

  localparam logic [sbae_pkg::SAMPLE_W-1:0] GROUP_MASK = 31;
  localparam int                            MAX_REPORTS = 60;

  string     glyphs = "+-0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
  enc_char_t due_chars[$];
  int        column = 0;
  int        mismatches = 0;

  assign fail_count = mismatches;

  // Split one sample into its codes and queue the characters it will produce.
  task automatic encode_sample(input logic [sbae_pkg::SAMPLE_W-1:0] raw, input logic fin);
    logic                          neg;
    logic [sbae_pkg::SAMPLE_W-1:0] mag;
    sbae_pkg::code_t               codes[sbae_pkg::MAX_CHARS];
    int                            n;
    int                            i;
    enc_char_t                     c;
    neg = raw[sbae_pkg::SAMPLE_W-1];
    mag = neg ? -raw : raw;
    if (mag > sbae_pkg::SAMPLE_W'(sbae_pkg::MAG_MAX)) begin
      mag = sbae_pkg::SAMPLE_W'(sbae_pkg::MAG_MAX);
    end
    if (mag < sbae_pkg::LIMIT_1)      n = 1;
    else if (mag < sbae_pkg::LIMIT_2) n = 2;
    else if (mag < sbae_pkg::LIMIT_3) n = 3;
    else if (mag < sbae_pkg::LIMIT_4) n = 4;
    else if (mag < sbae_pkg::LIMIT_5) n = 5;
    else                              n = 6;
    codes[0] = sbae_pkg::code_t'(mag >> (sbae_pkg::GROUP_W * (n - 1)))
             + (neg ? sbae_pkg::SIGN_BIT : sbae_pkg::code_t'(0))
             + ((n > 1) ? sbae_pkg::CONT_BIT : sbae_pkg::code_t'(0));
    for (i = 1; i < n; i++) begin
      codes[i] = sbae_pkg::code_t'((mag >> (sbae_pkg::GROUP_W * (n - 1 - i))) & GROUP_MASK)
               + ((i < n - 1) ? sbae_pkg::CONT_BIT : sbae_pkg::code_t'(0));
    end
    for (i = 0; i < n; i++) begin
      if (column >= LINE_LEN) begin
        c.ascii   = sbae_pkg::NEWLINE_CODE;
        c.run_end = 1'b0;
        c.pad     = '0;
        due_chars.push_back(c);
        column = 0;
      end
      column++;
      c.ascii   = sbae_pkg::ASCII_W'(glyphs[codes[i]]);
      c.run_end = (i == n - 1);
      c.pad     = (c.run_end && fin && column < LINE_LEN) ?
                  sbae_pkg::COL_W'(LINE_LEN - column) : '0;
      due_chars.push_back(c);
    end
    if (fin) column = 0;
  endtask

  task automatic check_char();
    enc_char_t                    want;
    logic [sbae_pkg::ASCII_W-1:0] got_ascii;
    logic [sbae_pkg::COL_W-1:0]   got_pad;
    logic                         bad;
    got_ascii = m_tdata[sbae_pkg::ASCII_W-1:0];
    got_pad   = m_tdata[sbae_pkg::ASCII_W +: sbae_pkg::COL_W];
    bad       = 1'b0;
    if (due_chars.size() == 0) begin
      mismatches++;
      if (mismatches < MAX_REPORTS)
        $display("%0t: char_code expected none, actual %0d", $time, got_ascii);
    end else begin
      want = due_chars.pop_front();
      if (got_ascii !== want.ascii) begin
        bad = 1'b1;
        if (mismatches < MAX_REPORTS)
          $display("%0t: char_code expected %0d, actual %0d", $time, want.ascii, got_ascii);
      end
      if (m_tlast !== want.run_end) begin
        bad = 1'b1;
        if (mismatches < MAX_REPORTS)
          $display("%0t: last_of_run expected %0d, actual %0d", $time, want.run_end, m_tlast);
      end
      if (got_pad !== want.pad) begin
        bad = 1'b1;
        if (mismatches < MAX_REPORTS)
          $display("%0t: pad_blanks expected %0d, actual %0d", $time, want.pad, got_pad);
      end
      if (bad) mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      due_chars.delete();
      column = 0;
      chars_due <= 0;
    end else begin
      if (s_tvalid && s_tready) encode_sample(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_char();
      chars_due <= due_chars.size();
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives signed samples into the six-bit encoder with random gaps on both
// channels, a long output hold and full-line streams; a checker instance
// predicts every character and the top reports the verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LINE_LEN       = 80;
  localparam int RX_HOLD_CYCLES = 300;   // long output hold, fills the block
  localparam int DRAIN_CYCLES   = 20;    // quiet time after the last character
  localparam int MAX_GAP        = 10;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [sbae_pkg::SAMPLE_W-1:0]   s_tdata;   // [31:0] sample
  logic                            s_tlast;   // final_sample
  logic                            m_tvalid;
  logic                            m_tready;
  logic [sbae_pkg::OUT_DATA_W-1:0] m_tdata;   // [6:0] char_code, [13:7] pad_blanks
  logic                            m_tlast;   // last_of_run

  int chars_due;
  int fail_count;

  // Idle controls: the sender reads tx_burst itself, the receiver process
  // reads rx_burst and long_hold_req, so those two change by nonblocking write.
  bit tx_burst      = 1'b0;
  bit rx_burst      = 1'b0;
  bit long_hold_req = 1'b0;

  // Characters on the current output line, tracked to shape full-line streams.
  int line_fill = 0;

  // Field extremes: every code-count boundary, saturation and the most
  // negative sample.
  logic [sbae_pkg::SAMPLE_W-1:0] boundary_vals [0:20] = '{
    32'd0, 32'd15, -32'sd15, 32'd16, -32'sd16, 32'd511, -32'sd512, 32'd512,
    32'd16383, 32'd16384, -32'sd16384, 32'd524287, 32'd524288, 32'd16777215,
    -32'sd16777216, 32'd134217727, 32'd134217728, -32'sd134217727,
    32'h7FFF_FFFF, 32'h8000_0000, -32'sd1
  };

  six_bit_ascii_sample_encoder_top #(
    .LINE_LENGTH(LINE_LEN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  sbae_char_checker #(
    .LINE_LEN(LINE_LEN)
  ) char_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .chars_due  (chars_due),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Draw a sample that encodes to exactly len characters, with a random sign.
  // The top class reaches past saturation up to the most negative value.
  function automatic logic [sbae_pkg::SAMPLE_W-1:0] sample_of_len(input int len);
    logic [sbae_pkg::SAMPLE_W-1:0] lo;
    logic [sbae_pkg::SAMPLE_W-1:0] hi;
    logic [sbae_pkg::SAMPLE_W-1:0] mag;
    case (len)
      1: begin
        lo = 0;
        hi = sbae_pkg::LIMIT_1 - 1;
      end
      2: begin
        lo = sbae_pkg::LIMIT_1;
        hi = sbae_pkg::LIMIT_2 - 1;
      end
      3: begin
        lo = sbae_pkg::LIMIT_2;
        hi = sbae_pkg::LIMIT_3 - 1;
      end
      4: begin
        lo = sbae_pkg::LIMIT_3;
        hi = sbae_pkg::LIMIT_4 - 1;
      end
      5: begin
        lo = sbae_pkg::LIMIT_4;
        hi = sbae_pkg::LIMIT_5 - 1;
      end
      default: begin
        lo = sbae_pkg::LIMIT_5;
        hi = 32'h8000_0000;
      end
    endcase
    mag = $urandom_range(hi, lo);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // Offer one request, after a random gap unless tx_burst is set, and hold it until the block takes it.
  // Returns at the falling edge after acceptance with tvalid still high, so a
  // back-to-back request needs no second write of tvalid in one step.
  task automatic send_sample(input logic [sbae_pkg::SAMPLE_W-1:0] smp, input logic fin);
    int                            gap;
    int                            n;
    int                            i;
    logic [sbae_pkg::SAMPLE_W-1:0] mag;
    mag = smp[sbae_pkg::SAMPLE_W-1] ? -smp : smp;
    n = (mag < sbae_pkg::LIMIT_1) ? 1 : (mag < sbae_pkg::LIMIT_2) ? 2 :
        (mag < sbae_pkg::LIMIT_3) ? 3 : (mag < sbae_pkg::LIMIT_4) ? 4 :
        (mag < sbae_pkg::LIMIT_5) ? 5 : 6;
    for (i = 0; i < n; i++) begin
      if (line_fill >= LINE_LEN) line_fill = 0;
      line_fill++;
    end
    if (fin) line_fill = 0;

    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Drop tvalid and hold the sender until every predicted character is out.
  task automatic wait_line_idle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (chars_due != 0);
  endtask

  // Fill the current line to exactly LINE_LEN characters, ending on a final
  // sample: this lands the stream end on a full line with zero padding.
  task automatic fill_line_stream();
    int room;
    int len;
    forever begin
      room = (line_fill >= LINE_LEN) ? LINE_LEN : LINE_LEN - line_fill;
      if (room <= sbae_pkg::MAX_CHARS) begin
        send_sample(sample_of_len(room), 1'b1);
        break;
      end
      len = $urandom_range(1, sbae_pkg::MAX_CHARS);
      send_sample(sample_of_len(len), 1'b0);
    end
  endtask

  // Receiver: a random stall before each character unless rx_burst is set, and once a long hold
  // counted here while the sender keeps pushing, so the input side backs up.
  initial begin
    int gap;
    bit long_hold_done;
    m_tready = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end
      gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    int i;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed extremes; two of them close a stream and report padding.
    for (i = 0; i <= 20; i++) begin
      send_sample(boundary_vals[i], (i == 10) || (i == 20));
    end

    // Noise: any 32-bit value, stream ends at random.
    repeat (30) send_sample($urandom, $urandom_range(0, 9) == 0);

    // Back-pressure: sender streams without gaps while the receiver holds.
    long_hold_req <= 1'b1;
    tx_burst = 1'b1;
    repeat (16) send_sample(sample_of_len($urandom_range(4, sbae_pkg::MAX_CHARS)), 1'b0);
    tx_burst = 1'b0;
    wait_line_idle();

    // Full-line streams, the second one with no idling on either side.
    fill_line_stream();
    rx_burst <= 1'b1;
    tx_burst = 1'b1;
    fill_line_stream();
    tx_burst = 1'b0;
    rx_burst <= 1'b0;

    // Tail of mixed lengths, closed by a final sample.
    repeat (9) send_sample(sample_of_len($urandom_range(1, sbae_pkg::MAX_CHARS)),
                           $urandom_range(0, 3) == 0);
    send_sample($urandom, 1'b1);

    wait_line_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hang guard, far above the slowest legal run.
  initial begin
    #500000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* six_bit_ascii_sample_encoder_top.f */
rtl/sbae_pkg.sv
rtl/six_bit_ascii_sample_encoder_top.sv
rtl/sbae_checker.sv
tb/sv/sbae_char_checker.sv
tb/sv/testbench.sv
